// File: rtl/core/assert_macros.svh
// assertion macros shared by the key press detector rtl
// no dependencies; each macro checks an implication on the rising clock edge
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/kslp_pkg.sv
// types and constants for the key short/long press detector
// no dependencies; used by the interfaces, the config block, the key cells and the top
package kslp_pkg;

    // payload widths of the request and result channels
    localparam int OP_W     = 2;
    localparam int LEVELS_W = 4;
    localparam int INDEX_W  = 2;
    localparam int EVENTS_W = 4;

    // threshold registers
    localparam int THR_W = 16;

    // config port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 2'd0,
        OP_CLR_SHORT = 2'd1,
        OP_CLR_LONG  = 2'd2,
        OP_CLR_ALL   = 2'd3
    } t_op;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_FILTER_TICKS = 2'd0;
    localparam logic [1:0] REG_LONG_TICKS   = 2'd1;
    localparam logic [1:0] REG_ACTIVE_LEVEL = 2'd2;

    // register reset values
    localparam logic [THR_W-1:0] FILTER_TICKS_RST = 16'd3;
    localparam logic [THR_W-1:0] LONG_TICKS_RST   = 16'd100;
    localparam logic             ACTIVE_LEVEL_RST = 1'b0;

    typedef struct packed {
        logic [THR_W-1:0] filter_ticks;
        logic [THR_W-1:0] long_press_ticks;
        logic             active_level;
    } t_cfg;

    typedef struct packed {
        logic tick;
        logic level;
        logic clr_short;
        logic clr_long;
    } t_key_ctrl;

endpackage

// File: rtl/core/kslp_ifs.sv
// valid/ready channel interfaces for key requests and press results
// depends on kslp_pkg for payload widths
interface kslp_in_if;
    logic                          valid;
    logic                          ready;
    logic [kslp_pkg::OP_W-1:0]     op;
    logic [kslp_pkg::LEVELS_W-1:0] key_levels;
    logic [kslp_pkg::INDEX_W-1:0]  key_index;

    modport source (output valid, output op, output key_levels, output key_index,
                    input ready);
    modport sink   (input valid, input op, input key_levels, input key_index,
                    output ready);
endinterface

interface kslp_out_if;
    logic                          valid;
    logic                          ready;
    logic [kslp_pkg::EVENTS_W-1:0] short_events;
    logic [kslp_pkg::EVENTS_W-1:0] long_events;

    modport source (output valid, output short_events, output long_events,
                    input ready);
    modport sink   (input valid, input short_events, input long_events,
                    output ready);
endinterface

// File: rtl/core/kslp_cfg_regs.sv
// apb-style configuration registers: filter time, long press time, active level
// depends on kslp_pkg
module kslp_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kslp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [kslp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [kslp_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output kslp_pkg::t_cfg                  o_cfg
);

    logic [kslp_pkg::THR_W-1:0] r_filter_ticks;
    logic [kslp_pkg::THR_W-1:0] r_long_ticks;
    logic                       r_active_level;
    logic [1:0]                 w_index;
    logic                       w_write;

    assign pready  = 1'b1;
    assign w_index = paddr[3:2];
    assign w_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_ticks <= kslp_pkg::FILTER_TICKS_RST;
            r_long_ticks   <= kslp_pkg::LONG_TICKS_RST;
            r_active_level <= kslp_pkg::ACTIVE_LEVEL_RST;
        end else if (w_write) begin
            case (w_index)
                kslp_pkg::REG_FILTER_TICKS: r_filter_ticks <= pwdata[kslp_pkg::THR_W-1:0];
                kslp_pkg::REG_LONG_TICKS:   r_long_ticks   <= pwdata[kslp_pkg::THR_W-1:0];
                kslp_pkg::REG_ACTIVE_LEVEL: r_active_level <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_index)
            kslp_pkg::REG_FILTER_TICKS: prdata = kslp_pkg::APB_DATA_W'(r_filter_ticks);
            kslp_pkg::REG_LONG_TICKS:   prdata = kslp_pkg::APB_DATA_W'(r_long_ticks);
            kslp_pkg::REG_ACTIVE_LEVEL: prdata = kslp_pkg::APB_DATA_W'(r_active_level);
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg.filter_ticks     = r_filter_ticks;
    assign o_cfg.long_press_ticks = r_long_ticks;
    assign o_cfg.active_level     = r_active_level;

endmodule

// File: rtl/core/kslp_key_cell.sv
// per-key state: last level, run and hold counters, sticky short and long flags
// depends on kslp_pkg and assert_macros.svh
`include "assert_macros.svh"

module kslp_key_cell #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kslp_pkg::t_cfg      i_cfg,
    input  kslp_pkg::t_key_ctrl i_ctrl,
    output logic                o_short_flag,
    output logic                o_long_flag
);

    localparam int CMP_W = COUNT_WIDTH + kslp_pkg::THR_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic                   r_prev;
    logic [COUNT_WIDTH-1:0] r_run;
    logic [COUNT_WIDTH-1:0] r_hold;
    logic                   r_short;
    logic                   r_long;

    logic                   n_prev;
    logic [COUNT_WIDTH-1:0] n_run;
    logic [COUNT_WIDTH-1:0] n_hold;
    logic                   n_short;
    logic                   n_long;

    logic [COUNT_WIDTH-1:0] w_run_inc;
    logic [COUNT_WIDTH-1:0] w_hold_inc;

    assign w_run_inc  = (r_run == CNT_MAX) ? r_run : r_run + COUNT_WIDTH'(1);
    assign w_hold_inc = (r_hold == CNT_MAX) ? r_hold : r_hold + COUNT_WIDTH'(1);

    always_comb begin
        n_prev  = r_prev;
        n_run   = r_run;
        n_hold  = r_hold;
        n_short = r_short;
        n_long  = r_long;
        if (i_ctrl.tick) begin
            n_prev = i_ctrl.level;
            if (r_prev == i_ctrl.level) begin
                n_run  = w_run_inc;
                n_hold = w_hold_inc;
                if (i_ctrl.level == i_cfg.active_level &&
                    CMP_W'(w_hold_inc) >= CMP_W'(i_cfg.long_press_ticks)) begin
                    // long press: restart hold count, skew run so release gives no short
                    n_run  = COUNT_WIDTH'(1);
                    n_hold = '0;
                    n_long = 1'b1;
                end
            end else begin
                if (r_prev == i_cfg.active_level && r_run == r_hold &&
                    CMP_W'(r_run) >= CMP_W'(i_cfg.filter_ticks)) begin
                    n_short = 1'b1;
                end
                n_run  = '0;
                n_hold = '0;
            end
        end
        if (i_ctrl.clr_short) begin
            n_short = 1'b0;
        end
        if (i_ctrl.clr_long) begin
            n_long = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= ~kslp_pkg::ACTIVE_LEVEL_RST;
            r_run   <= '0;
            r_hold  <= '0;
            r_short <= 1'b0;
            r_long  <= 1'b0;
        end else begin
            r_prev  <= n_prev;
            r_run   <= n_run;
            r_hold  <= n_hold;
            r_short <= n_short;
            r_long  <= n_long;
        end
    end

    assign o_short_flag = r_short;
    assign o_long_flag  = r_long;

    // a single tick can end a press or extend it, never both
    `ASSERT_NEXT(a_no_dual_event, i_clk, i_rst_n, i_ctrl.tick, !($rose(r_short) && $rose(r_long)))
    // tick always records the sampled level
    `ASSERT_NEXT(a_prev_follows, i_clk, i_rst_n, i_ctrl.tick, r_prev == $past(i_ctrl.level))
    // after a long press the counters disagree, so the release cannot be a short press
    `ASSERT_IMPLIES(a_long_skews, i_clk, i_rst_n, $rose(r_long), r_run != r_hold)

endmodule

// File: rtl/core/key_short_long_press_detector.sv
// top level of the key short/long press detector: input stage, key cells, result stage
// depends on kslp_pkg, kslp_ifs, kslp_cfg_regs, kslp_key_cell and assert_macros.svh
//
// Short/long key press detector for NUM_KEYS keys. Each request on in_ch is
// either a sample tick (op 0, raw key levels in key_levels) or a flag clear
// (op 1 clears the short flag of key_index, op 2 its long flag, op 3 all
// flags). Every request yields exactly one result on out_ch with the sticky
// short and long press flags after that request. The block takes one request
// per clock cycle while out_ch takes its results; while a result waits to be
// taken, the input stage holds one request and takes no more. A request is
// registered in the input stage, then once the result slot is free every key
// cell does its counter increment, threshold compare and flag update in one
// pass, and the updated flag registers are the result. The per-key saturating
// counter add and the compare against the 16-bit thresholds set the cycle.
// Thresholds and the active level sit in three registers on the 32-bit
// apb-style port at byte addresses 0 (filter_ticks), 4 (long_press_ticks) and
// 8 (active_level); they are meant to be written while the block is idle. Keys
// above the fourth see a constant low level and do not show on the 4-bit result
// fields. No memory, no clearing pass after reset.
`include "assert_macros.svh"

module key_short_long_press_detector #(
    parameter int NUM_KEYS    = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    kslp_in_if.sink                         in_ch,
    kslp_out_if.source                      out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kslp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [kslp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [kslp_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    // input stage
    logic                            r_in_valid;
    kslp_pkg::t_op                   r_op;
    logic [kslp_pkg::LEVELS_W-1:0]   r_levels;
    logic [kslp_pkg::INDEX_W-1:0]    r_index;

    // result stage valid; payload is the key cells' flag registers
    logic                            r_out_valid;

    logic                            w_advance;
    kslp_pkg::t_cfg                  w_cfg;
    logic [NUM_KEYS-1:0]             w_short;
    logic [NUM_KEYS-1:0]             w_long;

    // the request moves into the key cells when the result slot is free
    assign w_advance   = r_in_valid && (!r_out_valid || out_ch.ready);
    assign in_ch.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ch.ready) begin
                r_in_valid <= in_ch.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload of the input stage, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready) begin
            r_op     <= kslp_pkg::t_op'(in_ch.op);
            r_levels <= in_ch.key_levels;
            r_index  <= in_ch.key_index;
        end
    end

    kslp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        kslp_pkg::t_key_ctrl w_ctrl;

        // keys above the input field width read a low level
        if (k < kslp_pkg::LEVELS_W) begin : g_level
            assign w_ctrl.level = r_levels[k];
        end else begin : g_no_level
            assign w_ctrl.level = 1'b0;
        end

        assign w_ctrl.tick      = w_advance && (r_op == kslp_pkg::OP_TICK);
        // single-key clears only hit a key the index can name
        assign w_ctrl.clr_short = w_advance &&
            ((r_op == kslp_pkg::OP_CLR_SHORT && 32'(r_index) == k) ||
             r_op == kslp_pkg::OP_CLR_ALL);
        assign w_ctrl.clr_long  = w_advance &&
            ((r_op == kslp_pkg::OP_CLR_LONG && 32'(r_index) == k) ||
             r_op == kslp_pkg::OP_CLR_ALL);

        kslp_key_cell #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cfg        (w_cfg),
            .i_ctrl       (w_ctrl),
            .o_short_flag (w_short[k]),
            .o_long_flag  (w_long[k])
        );
    end

    // result fields show the first four keys; missing keys read zero
    for (genvar b = 0; b < kslp_pkg::EVENTS_W; b++) begin : g_evt
        if (b < NUM_KEYS) begin : g_used
            assign out_ch.short_events[b] = w_short[b];
            assign out_ch.long_events[b]  = w_long[b];
        end else begin : g_unused
            assign out_ch.short_events[b] = 1'b0;
            assign out_ch.long_events[b]  = 1'b0;
        end
    end

    assign out_ch.valid = r_out_valid;

    // a request waiting in the input stage is never dropped
    `ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_valid && !w_advance, r_in_valid)
    // every request that reaches the key cells produces a result
    `ASSERT_NEXT(a_adv_result, i_clk, i_rst_n, w_advance, r_out_valid)
    // a result that is not taken stays offered
    `ASSERT_NEXT(a_out_held, i_clk, i_rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)

endmodule
